/* hdl/amf_hdr_pkg.sv */
// shared types and constants for the amf command header parser
// no dependencies; used by every module of the block

package amf_hdr_pkg;

	// width of the internal byte position counter
	localparam int POSITION_BITS = 16;
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	localparam int BYTE_BITS = 8;
	localparam int FIELD_BITS = 16;
	localparam int TXN_BITS = 64;

	// configuration port
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS = 8;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_AMF0_TYPE = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_AMF3_TYPE = 1'b1;
	localparam logic [CFG_DATA_BITS-1:0] AMF0_TYPE_RESET = 8'd20;
	localparam logic [CFG_DATA_BITS-1:0] AMF3_TYPE_RESET = 8'd17;

	// message layout
	localparam logic [FIELD_BITS-1:0] HDR_BYTES = 16'd4;
	localparam logic [FIELD_BITS-1:0] LEN_BYTES = 16'd2;
	localparam logic [FIELD_BITS-1:0] TXN_BYTES = 16'd9;
	localparam logic [FIELD_BITS-1:0] NAME_OFFSET_BASE = 16'd8;
	localparam logic [BYTE_BITS-1:0] AMF3_MARKER = 8'd0;
	localparam logic [BYTE_BITS-1:0] STRING_MARKER = 8'd2;

	typedef struct packed {
		logic [BYTE_BITS-1:0] data_byte;
		logic                 final_byte;
	} byte_req_t;

	typedef struct packed {
		logic                  error;
		logic                  is_amf3;
		logic [FIELD_BITS-1:0] name_offset;
		logic [FIELD_BITS-1:0] name_length;
		logic [TXN_BITS-1:0]   transaction_id;
		logic [FIELD_BITS-1:0] argument_offset;
		logic [FIELD_BITS-1:0] argument_length;
	} result_t;

endpackage

/* hdl/amf_hdr_in_stage.sv */
// input register stage: holds one accepted byte request for the parser
// depends on amf_hdr_pkg

module amf_hdr_in_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  amf_hdr_pkg::byte_req_t in_req,
	output logic                  req_valid,
	output amf_hdr_pkg::byte_req_t req,
	input  logic                  req_take
);

	logic                   valid_s1;
	amf_hdr_pkg::byte_req_t req_s1;
	logic                   accept;

	// stage is free when empty or being drained this cycle
	assign in_stall = valid_s1 && !req_take;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (req_take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= in_req;
		end
	end

	assign req_valid = valid_s1;
	assign req = req_s1;

endmodule

/* hdl/amf_hdr_core.sv */
// parser state machine, type code registers and result register
// depends on amf_hdr_pkg

module amf_hdr_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_write,
	input  logic [amf_hdr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [amf_hdr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                   req_valid,
	input  amf_hdr_pkg::byte_req_t                 req,
	output logic                                   req_take,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output amf_hdr_pkg::result_t                   result
);

	typedef enum logic [2:0] {
		PH_TYPE,
		PH_HDR,
		PH_MARK,
		PH_STR,
		PH_LEN,
		PH_NAME,
		PH_TXN,
		PH_ARGS
	} phase_t;

	phase_t                                   phase_q, phase_n;
	logic [amf_hdr_pkg::POSITION_BITS-1:0]    pos_q, pos_n;
	logic [amf_hdr_pkg::FIELD_BITS-1:0]       name_q, name_n;
	logic [amf_hdr_pkg::FIELD_BITS-1:0]       left_q, left_n;
	logic                                     amf3_q, amf3_n;
	logic [amf_hdr_pkg::TXN_BITS-1:0]         txn_q, txn_n;
	logic                                     failed_q, failed_n;
	logic [amf_hdr_pkg::CFG_DATA_BITS-1:0]    amf0_code_q, amf3_code_q;

	logic                                     out_valid_q;
	amf_hdr_pkg::result_t                     result_q, result_n;
	logic                                     out_free, emit;
	logic [amf_hdr_pkg::BYTE_BITS-1:0]        b;
	logic [31:0]                              pos_ext;
	logic [amf_hdr_pkg::FIELD_BITS-1:0]       noff, aoff;

	assign b = req.data_byte;
	assign out_free = !out_valid_q || !out_stall;
	// a plain byte never waits; the final byte waits for a free result slot
	assign req_take = req_valid && (!req.final_byte || out_free);
	assign emit = req_take && req.final_byte;

	always_comb begin
		phase_n = phase_q;
		pos_n = pos_q;
		name_n = name_q;
		left_n = left_q;
		amf3_n = amf3_q;
		txn_n = txn_q;
		failed_n = failed_q;
		if (pos_q == amf_hdr_pkg::POS_MAX) begin
			failed_n = 1'b1;
		end else begin
			pos_n = pos_q + 1'b1;
			if (!failed_q) begin
				case (phase_q)
					PH_TYPE: begin
						if (b == amf0_code_q) begin
							amf3_n = 1'b0;
						end else if (b == amf3_code_q) begin
							amf3_n = 1'b1;
						end else begin
							failed_n = 1'b1;
						end
						phase_n = PH_HDR;
						left_n = amf_hdr_pkg::HDR_BYTES;
					end
					PH_HDR: begin
						left_n = left_q - 1'b1;
						if (left_q == 16'd1) begin
							phase_n = amf3_q ? PH_MARK : PH_STR;
						end
					end
					PH_MARK: begin
						if (b != amf_hdr_pkg::AMF3_MARKER) begin
							failed_n = 1'b1;
						end
						phase_n = PH_STR;
					end
					PH_STR: begin
						if (b != amf_hdr_pkg::STRING_MARKER) begin
							failed_n = 1'b1;
						end
						phase_n = PH_LEN;
						left_n = amf_hdr_pkg::LEN_BYTES;
					end
					PH_LEN: begin
						name_n = {name_q[amf_hdr_pkg::FIELD_BITS-amf_hdr_pkg::BYTE_BITS-1:0], b};
						left_n = left_q - 1'b1;
						if (left_q == 16'd1) begin
							if (name_n == '0) begin
								phase_n = PH_TXN;
								left_n = amf_hdr_pkg::TXN_BYTES;
							end else begin
								phase_n = PH_NAME;
								left_n = name_n;
							end
						end
					end
					PH_NAME: begin
						left_n = left_q - 1'b1;
						if (left_q == 16'd1) begin
							phase_n = PH_TXN;
							left_n = amf_hdr_pkg::TXN_BYTES;
						end
					end
					PH_TXN: begin
						// first byte of the id field is a skipped marker
						if (left_q != amf_hdr_pkg::TXN_BYTES) begin
							txn_n = {txn_q[amf_hdr_pkg::TXN_BITS-amf_hdr_pkg::BYTE_BITS-1:0], b};
						end
						left_n = left_q - 1'b1;
						if (left_q == 16'd1) begin
							phase_n = PH_ARGS;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// result fields from the state after this byte
	assign pos_ext = 32'(pos_n);
	assign noff = amf_hdr_pkg::NAME_OFFSET_BASE + {15'b0, amf3_n};
	assign aoff = noff + name_n + amf_hdr_pkg::TXN_BYTES;

	always_comb begin
		result_n = '0;
		if (failed_n || phase_n != PH_ARGS) begin
			result_n.error = 1'b1;
		end else begin
			result_n.is_amf3 = amf3_n;
			result_n.name_offset = noff;
			result_n.name_length = name_n;
			result_n.transaction_id = txn_n;
			result_n.argument_offset = aoff;
			result_n.argument_length = pos_ext[amf_hdr_pkg::FIELD_BITS-1:0] - aoff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			pos_q <= '0;
			name_q <= '0;
			left_q <= '0;
			amf3_q <= 1'b0;
			txn_q <= '0;
			failed_q <= 1'b0;
		end else if (emit) begin
			phase_q <= PH_TYPE;
			pos_q <= '0;
			name_q <= '0;
			left_q <= '0;
			amf3_q <= 1'b0;
			txn_q <= '0;
			failed_q <= 1'b0;
		end else if (req_take) begin
			phase_q <= phase_n;
			pos_q <= pos_n;
			name_q <= name_n;
			left_q <= left_n;
			amf3_q <= amf3_n;
			txn_q <= txn_n;
			failed_q <= failed_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amf0_code_q <= amf_hdr_pkg::AMF0_TYPE_RESET;
			amf3_code_q <= amf_hdr_pkg::AMF3_TYPE_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				amf_hdr_pkg::CFG_AMF0_TYPE: amf0_code_q <= cfg_data;
				amf_hdr_pkg::CFG_AMF3_TYPE: amf3_code_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q <= result_n;
		end
	end

	assign out_valid = out_valid_q;
	assign result = result_q;

endmodule

/* hdl/amf_command_header_parser_top.sv */
// top level of the amf command header parser
// depends on amf_hdr_pkg, amf_hdr_in_stage and amf_hdr_core

// Takes one message byte per clock unless a final byte waits for the result
// register; each byte is a single phase and counter step of the parser, done
// between the input and result registers. A message's one result is registered
// when the core takes its final byte; while a result waits on out_stall, more
// non-final bytes are still accepted and parsed, and only the next final byte
// holds until the result register is free. The user must write type codes via
// cfg_write, cfg_index and cfg_data only while the block is idle; not enforced.

module amf_command_header_parser_top (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_write,
	input  logic [amf_hdr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [amf_hdr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic [amf_hdr_pkg::BYTE_BITS-1:0]       data_byte,
	input  logic                                    final_byte,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic                                    error,
	output logic                                    is_amf3,
	output logic [amf_hdr_pkg::FIELD_BITS-1:0]      name_offset,
	output logic [amf_hdr_pkg::FIELD_BITS-1:0]      name_length,
	output logic [amf_hdr_pkg::TXN_BITS-1:0]        transaction_id,
	output logic [amf_hdr_pkg::FIELD_BITS-1:0]      argument_offset,
	output logic [amf_hdr_pkg::FIELD_BITS-1:0]      argument_length
);

	amf_hdr_pkg::byte_req_t in_req, req;
	amf_hdr_pkg::result_t   result;
	logic                   req_valid, req_take;

	assign in_req.data_byte = data_byte;
	assign in_req.final_byte = final_byte;

	amf_hdr_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_req   (in_req),
		.req_valid(req_valid),
		.req      (req),
		.req_take (req_take)
	);

	amf_hdr_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req_valid(req_valid),
		.req      (req),
		.req_take (req_take),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result   (result)
	);

	assign error = result.error;
	assign is_amf3 = result.is_amf3;
	assign name_offset = result.name_offset;
	assign name_length = result.name_length;
	assign transaction_id = result.transaction_id;
	assign argument_offset = result.argument_offset;
	assign argument_length = result.argument_length;

endmodule

/* hdl/amf_hdr_checker.sv */
// port-level checks of the amf command header parser results
// depends on amf_hdr_pkg; bound to amf_command_header_parser_top

module amf_hdr_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic                               error,
	input logic                               is_amf3,
	input logic [amf_hdr_pkg::FIELD_BITS-1:0] name_offset,
	input logic [amf_hdr_pkg::FIELD_BITS-1:0] name_length,
	input logic [amf_hdr_pkg::TXN_BITS-1:0]   transaction_id,
	input logic [amf_hdr_pkg::FIELD_BITS-1:0] argument_offset,
	input logic [amf_hdr_pkg::FIELD_BITS-1:0] argument_length
);

	logic [amf_hdr_pkg::FIELD_BITS-1:0] aoff_expect;

	assign aoff_expect = name_offset + name_length + amf_hdr_pkg::TXN_BYTES;

	// an error result carries nothing else
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> !is_amf3 && name_offset == '0 && name_length == '0
			&& transaction_id == '0 && argument_offset == '0 && argument_length == '0)
		else $error("error result with nonzero fields");

	// name starts after the header, one later for the amf3 marker
	a_name_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !error |-> name_offset ==
			(amf_hdr_pkg::NAME_OFFSET_BASE + {15'b0, is_amf3}))
		else $error("name offset does not match message type");

	// arguments follow the name and the id field
	a_arg_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !error |-> argument_offset == aoff_expect)
		else $error("argument offset inconsistent with name fields");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(error) && $stable(transaction_id)
			&& $stable(argument_length))
		else $error("stalled result changed");

endmodule

bind amf_command_header_parser_top amf_hdr_checker u_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.error          (error),
	.is_amf3        (is_amf3),
	.name_offset    (name_offset),
	.name_length    (name_length),
	.transaction_id (transaction_id),
	.argument_offset(argument_offset),
	.argument_length(argument_length)
);

/* tb/amf_command_header_parser_top_tb.sv */
// testbench for amf_command_header_parser_top: byte requests in, header results checked
// against a parser model kept here; depends on amf_hdr_pkg and the rtl top level

module amf_command_header_parser_top_tb;

	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_BYTES = 1450;
	localparam int LONG_NAME = 300;

	typedef enum logic [2:0] {
		ST_TYPE, ST_HEADER, ST_MARKER, ST_STRING, ST_LENGTH, ST_NAME, ST_TXN, ST_ARGS
	} phase_t;

	logic                                    clk = 1'b0;
	logic                                    arst_n = 1'b0;
	logic                                    cfg_write = 1'b0;
	logic [amf_hdr_pkg::CFG_INDEX_BITS-1:0]  cfg_index = amf_hdr_pkg::CFG_AMF0_TYPE;
	logic [amf_hdr_pkg::CFG_DATA_BITS-1:0]   cfg_data = '0;
	logic                                    in_valid = 1'b0;
	logic                                    in_stall;
	logic [amf_hdr_pkg::BYTE_BITS-1:0]       data_byte = '0;
	logic                                    final_byte = 1'b0;
	logic                                    out_valid;
	logic                                    out_stall = 1'b0;
	logic                                    error;
	logic                                    is_amf3;
	logic [amf_hdr_pkg::FIELD_BITS-1:0]      name_offset;
	logic [amf_hdr_pkg::FIELD_BITS-1:0]      name_length;
	logic [amf_hdr_pkg::TXN_BITS-1:0]        transaction_id;
	logic [amf_hdr_pkg::FIELD_BITS-1:0]      argument_offset;
	logic [amf_hdr_pkg::FIELD_BITS-1:0]      argument_length;

	// parser model state and its copy of the type codes
	logic [amf_hdr_pkg::CFG_DATA_BITS-1:0]   amf0_code = amf_hdr_pkg::AMF0_TYPE_RESET;
	logic [amf_hdr_pkg::CFG_DATA_BITS-1:0]   amf3_code = amf_hdr_pkg::AMF3_TYPE_RESET;
	phase_t                                  phase = ST_TYPE;
	logic [amf_hdr_pkg::POSITION_BITS-1:0]   position = '0;
	logic [amf_hdr_pkg::FIELD_BITS-1:0]      name_size = '0;
	logic [amf_hdr_pkg::FIELD_BITS-1:0]      field_left = '0;
	logic                                    amf3_msg = 1'b0;
	logic [amf_hdr_pkg::TXN_BITS-1:0]        txn_bytes = '0;
	logic                                    msg_failed = 1'b0;

	amf_hdr_pkg::result_t                    pending_headers[$];
	logic [amf_hdr_pkg::BYTE_BITS-1:0]       msg_bytes[$];
	int                                      mismatches = 0;
	int                                      tx_idle_pct = 9;
	int                                      rx_idle_pct = 83;
	int                                      hold_reqs = 0;
	int                                      hold_seen = 0;
	int                                      hold_left = 0;

	amf_command_header_parser_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.data_byte       (data_byte),
		.final_byte      (final_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.error           (error),
		.is_amf3         (is_amf3),
		.name_offset     (name_offset),
		.name_length     (name_length),
		.transaction_id  (transaction_id),
		.argument_offset (argument_offset),
		.argument_length (argument_length)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// advances the parser model by one byte; returns 1 when the byte closes a message
	function automatic bit parse_byte(input logic [amf_hdr_pkg::BYTE_BITS-1:0] value,
			input logic last, output amf_hdr_pkg::result_t res);
		logic [amf_hdr_pkg::FIELD_BITS-1:0] name_at;
		logic [amf_hdr_pkg::FIELD_BITS-1:0] args_at;
		res = '0;
		if (position == amf_hdr_pkg::POS_MAX) begin
			msg_failed = 1'b1;
		end else begin
			if (!msg_failed) begin
				case (phase)
					ST_TYPE: begin
						if (value == amf0_code)
							amf3_msg = 1'b0;
						else if (value == amf3_code)
							amf3_msg = 1'b1;
						else
							msg_failed = 1'b1;
						phase = ST_HEADER;
						field_left = amf_hdr_pkg::HDR_BYTES;
					end
					ST_HEADER: begin
						field_left = field_left - 1'b1;
						if (field_left == 0)
							phase = amf3_msg ? ST_MARKER : ST_STRING;
					end
					ST_MARKER: begin
						if (value != amf_hdr_pkg::AMF3_MARKER)
							msg_failed = 1'b1;
						phase = ST_STRING;
					end
					ST_STRING: begin
						if (value != amf_hdr_pkg::STRING_MARKER)
							msg_failed = 1'b1;
						phase = ST_LENGTH;
						field_left = amf_hdr_pkg::LEN_BYTES;
					end
					ST_LENGTH: begin
						name_size = {name_size[7:0], value};
						field_left = field_left - 1'b1;
						if (field_left == 0) begin
							if (name_size == 0) begin
								phase = ST_TXN;
								field_left = amf_hdr_pkg::TXN_BYTES;
							end else begin
								phase = ST_NAME;
								field_left = name_size;
							end
						end
					end
					ST_NAME: begin
						field_left = field_left - 1'b1;
						if (field_left == 0) begin
							phase = ST_TXN;
							field_left = amf_hdr_pkg::TXN_BYTES;
						end
					end
					ST_TXN: begin
						// first of the nine bytes is a skipped byte
						if (field_left != amf_hdr_pkg::TXN_BYTES)
							txn_bytes = {txn_bytes[amf_hdr_pkg::TXN_BITS-9:0], value};
						field_left = field_left - 1'b1;
						if (field_left == 0)
							phase = ST_ARGS;
					end
					default: begin
					end
				endcase
			end
			position = position + 1'b1;
		end
		if (!last)
			return 1'b0;
		if (msg_failed || phase != ST_ARGS) begin
			res.error = 1'b1;
		end else begin
			name_at = amf_hdr_pkg::NAME_OFFSET_BASE + 16'(amf3_msg);
			args_at = name_at + name_size + amf_hdr_pkg::TXN_BYTES;
			res.is_amf3 = amf3_msg;
			res.name_offset = name_at;
			res.name_length = name_size;
			res.transaction_id = txn_bytes;
			res.argument_offset = args_at;
			res.argument_length = position - args_at;
		end
		phase = ST_TYPE;
		position = '0;
		name_size = '0;
		field_left = '0;
		amf3_msg = 1'b0;
		txn_bytes = '0;
		msg_failed = 1'b0;
		return 1'b1;
	endfunction

	task automatic check_field(input string field,
			input logic [amf_hdr_pkg::TXN_BITS-1:0] want_val,
			input logic [amf_hdr_pkg::TXN_BITS-1:0] got_val);
		if (got_val !== want_val) begin
			$display("%0t: %s expected %0h actual %0h", $time, field, want_val, got_val);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : check_results
		amf_hdr_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_headers.size() == 0) begin
				$display("%0t: expected no result, actual error=%0b amf3=%0b name=%0h/%0h id=%0h args=%0h/%0h",
					$time, error, is_amf3, name_offset, name_length, transaction_id,
					argument_offset, argument_length);
				mismatches++;
			end else begin
				want = pending_headers.pop_front();
				check_field("error", 64'(want.error), 64'(error));
				check_field("is_amf3", 64'(want.is_amf3), 64'(is_amf3));
				check_field("name_offset", 64'(want.name_offset), 64'(name_offset));
				check_field("name_length", 64'(want.name_length), 64'(name_length));
				check_field("transaction_id", want.transaction_id, transaction_id);
				check_field("argument_offset", 64'(want.argument_offset),
					64'(argument_offset));
				check_field("argument_length", 64'(want.argument_length),
					64'(argument_length));
			end
		end
	end

	// receiver: random stall, or a long hold-off when one is asked for
	always @(negedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	task automatic send_byte(input logic [amf_hdr_pkg::BYTE_BITS-1:0] value,
			input logic last);
		amf_hdr_pkg::result_t res;
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= value;
		final_byte <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (parse_byte(value, last, res))
			pending_headers.push_back(res);
	endtask

	task automatic send_message();
		for (int i = 0; i < msg_bytes.size(); i++)
			send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
	endtask

	task automatic wait_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_headers.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_type_code(input logic [amf_hdr_pkg::CFG_INDEX_BITS-1:0] index,
			input logic [amf_hdr_pkg::CFG_DATA_BITS-1:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		if (index == amf_hdr_pkg::CFG_AMF0_TYPE)
			amf0_code = value;
		else
			amf3_code = value;
	endtask

	task automatic set_type_codes(input logic [amf_hdr_pkg::CFG_DATA_BITS-1:0] amf0_val,
			input logic [amf_hdr_pkg::CFG_DATA_BITS-1:0] amf3_val);
		wait_drain();
		write_type_code(amf_hdr_pkg::CFG_AMF0_TYPE, amf0_val);
		write_type_code(amf_hdr_pkg::CFG_AMF3_TYPE, amf3_val);
	endtask

	function automatic logic [amf_hdr_pkg::BYTE_BITS-1:0] other_type();
		logic [amf_hdr_pkg::BYTE_BITS-1:0] v;
		v = 8'($urandom_range(255));
		while (v == amf0_code || v == amf3_code)
			v = 8'($urandom_range(255));
		return v;
	endfunction

	// well-formed message with random header, name, id and argument bytes
	task automatic build_message(input bit use3, input int nlen, input int alen);
		logic [amf_hdr_pkg::FIELD_BITS-1:0] len16;
		len16 = 16'(nlen);
		msg_bytes.delete();
		msg_bytes.push_back(use3 ? amf3_code : amf0_code);
		repeat (amf_hdr_pkg::HDR_BYTES) msg_bytes.push_back(8'($urandom_range(255)));
		if (use3)
			msg_bytes.push_back(amf_hdr_pkg::AMF3_MARKER);
		msg_bytes.push_back(amf_hdr_pkg::STRING_MARKER);
		msg_bytes.push_back(len16[15:8]);
		msg_bytes.push_back(len16[7:0]);
		repeat (nlen + amf_hdr_pkg::TXN_BYTES + alen)
			msg_bytes.push_back(8'($urandom_range(255)));
	endtask

	task automatic test_directed_messages();
		int txn_at;
		// shortest amf0 message, header bytes at both extremes
		build_message(1'b0, 0, 0);
		msg_bytes[1] = 8'h00;
		msg_bytes[2] = 8'hFF;
		msg_bytes[3] = 8'h00;
		msg_bytes[4] = 8'hFF;
		send_message();
		// amf3 with an all-ones id
		build_message(1'b1, 2, 3);
		txn_at = 9 + 1 + 2;
		for (int i = 0; i < 8; i++)
			msg_bytes[txn_at + i] = 8'hFF;
		send_message();
		// amf3 with a zero id and no arguments
		build_message(1'b1, 0, 0);
		txn_at = 9 + 1;
		for (int i = 0; i < 8; i++)
			msg_bytes[txn_at + i] = 8'h00;
		send_message();
		// unknown type, later bytes only counted
		build_message(1'b0, 4, 2);
		msg_bytes[0] = other_type();
		send_message();
		// amf3 marker not zero
		build_message(1'b1, 1, 1);
		msg_bytes[5] = 8'h01;
		send_message();
		// wrong string marker
		build_message(1'b0, 1, 1);
		msg_bytes[5] = 8'h03;
		send_message();
		// final byte inside the transaction id
		build_message(1'b0, 2, 0);
		void'(msg_bytes.pop_back());
		send_message();
		// final on the type byte itself
		send_byte(amf0_code, 1'b1);
		// largest name length, cut short
		build_message(1'b0, 0, 0);
		msg_bytes[6] = 8'hFF;
		msg_bytes[7] = 8'hFF;
		send_message();
	endtask

	task automatic test_type_codes();
		logic [amf_hdr_pkg::CFG_DATA_BITS-1:0] same;
		for (int k = 0; k < 4; k++) begin
			case (k)
				0: set_type_codes(8'h00, 8'hFF);
				1: set_type_codes(8'hFF, 8'h00);
				2: begin
					// both codes equal, amf0 wins
					same = 8'($urandom_range(255));
					set_type_codes(same, same);
				end
				default: set_type_codes(amf_hdr_pkg::AMF0_TYPE_RESET,
					amf_hdr_pkg::AMF3_TYPE_RESET);
			endcase
			build_message(1'b0, 3, 2);
			send_message();
			build_message(1'b1, 1, 0);
			send_message();
			build_message(1'b0, 1, 1);
			msg_bytes[0] = other_type();
			send_message();
		end
	endtask

	task automatic test_backpressure();
		wait_drain();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_reqs++;
		repeat (6) begin
			build_message(1'($urandom_range(1)), $urandom_range(4), $urandom_range(3));
			send_message();
		end
		// sender pauses until every result has come
		wait_drain();
	endtask

	task automatic test_long_messages();
		int args;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		// exactly the largest position, still good
		args = amf_hdr_pkg::POS_MAX - (1 + amf_hdr_pkg::HDR_BYTES + 1
			+ amf_hdr_pkg::LEN_BYTES + LONG_NAME + amf_hdr_pkg::TXN_BYTES);
		build_message(1'b0, LONG_NAME, args);
		send_message();
		// one byte more than the position range
		build_message(1'b0, LONG_NAME, args + 1);
		send_message();
		wait_drain();
	endtask

	task automatic test_random_traffic();
		int sent;
		int kind;
		int cut;
		int nlen;
		bit use3;
		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					tx_idle_pct = 9;
					rx_idle_pct = 83;
				end
				1: begin
					tx_idle_pct = 83;
					rx_idle_pct = 9;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			set_type_codes(8'($urandom_range(255)), 8'($urandom_range(255)));
			sent = 0;
			while (sent < RANDOM_BYTES / 3) begin
				kind = $urandom_range(99);
				use3 = 1'($urandom_range(1));
				nlen = ($urandom_range(29) == 0) ? $urandom_range(200, 400) : $urandom_range(12);
				build_message(use3, nlen, $urandom_range(10));
				if (kind < 70) begin
				end else if (kind < 76) begin
					msg_bytes[0] = other_type();
				end else if (kind < 82) begin
					msg_bytes[5 + use3] = amf_hdr_pkg::STRING_MARKER
						^ 8'($urandom_range(1, 255));
				end else if (kind < 86) begin
					if (use3)
						msg_bytes[5] = 8'($urandom_range(1, 255));
				end else if (kind < 95) begin
					cut = $urandom_range(1, msg_bytes.size() - 1);
					while (msg_bytes.size() > cut)
						void'(msg_bytes.pop_back());
				end else begin
					msg_bytes.delete();
					repeat ($urandom_range(1, 24))
						msg_bytes.push_back(8'($urandom_range(255)));
				end
				sent += msg_bytes.size();
				send_message();
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_messages();
		test_type_codes();
		test_backpressure();
		test_long_messages();
		test_random_traffic();
		wait_drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

/* sim.f */
hdl/amf_hdr_pkg.sv
hdl/amf_hdr_in_stage.sv
hdl/amf_hdr_core.sv
hdl/amf_command_header_parser_top.sv
hdl/amf_hdr_checker.sv
tb/amf_command_header_parser_top_tb.sv
